// ===== design/txrc_pkg.sv =====
// shared types and constants for the text record charset transcoder
package txrc_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_REC  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // special input bytes
  localparam logic [7:0] BYTE_AT = 8'h40;
  localparam logic [7:0] BYTE_NL = 8'h0a;
  localparam logic [7:0] BYTE_E2 = 8'he2;
  localparam logic [7:0] BYTE_99 = 8'h99;
  localparam logic [7:0] BYTE_82 = 8'h82;
  localparam logic [7:0] BYTE_80 = 8'h80;
  localparam logic [7:0] BYTE_C2 = 8'hc2;
  localparam logic [7:0] BYTE_A5 = 8'ha5;
  localparam logic [7:0] BYTE_B7 = 8'hb7;
  localparam logic [7:0] BYTE_C3 = 8'hc3;
  localparam logic [7:0] BYTE_A9 = 8'ha9;
  localparam logic [7:0] BYTE_97 = 8'h97;

  // mapped output bytes
  localparam logic [7:0] OUT_A9 = 8'ha9;
  localparam logic [7:0] OUT_BE = 8'hbe;
  localparam logic [7:0] OUT_A5 = 8'ha5;
  localparam logic [7:0] OUT_B7 = 8'hb7;
  localparam logic [7:0] OUT_E9 = 8'he9;
  localparam logic [7:0] OUT_D7 = 8'hd7;
  localparam logic [7:0] OUT_ZERO = 8'h00;

  // one result item
  typedef struct packed {
    logic [7:0] byte_val;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage

// ===== design/text_record_charset_transcoder.sv =====
// Top level of the text record charset transcoder.
//
// Input channel: in_byte and in_end_of_input with in_valid / in_stall. One
// raw byte, or an end-of-stream mark, moves per transaction.
// Result channel: out_byte, out_kind and out_last_of_run with out_valid /
// out_stall. out_kind is 0 data, 1 record end, 2 stream end, 3 error, and
// out_last_of_run marks the final result caused by one input transaction.
// An input gives zero, one or two results.
// An accepted byte is registered in the input stage, decoded, and its results
// are written into the result queue. Throughput: one input per cycle while
// each input gives at most one result and the receiver does not stall; an
// input giving two results can raise in_stall, set by the single result
// port reading one entry of the 4-entry result queue per cycle.
// Reset (rst_n low, synchronous) empties the queue and the input stage and
// puts the decoder in plain state. After an error the decoder is halted:
// inputs are still taken but give no results until reset.
// When the receiver stalls, results wait in the queue; input transactions
// continue to be taken until the queue could overflow, then in_stall rises.
module text_record_charset_transcoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last_of_run
);
  import txrc_pkg::*;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_E2    = 3'd1,
    MODE_E2_99 = 3'd2,
    MODE_C2    = 3'd3,
    MODE_C3    = 3'd4,
    MODE_NL    = 3'd5,
    MODE_HALT  = 3'd6
  } mode_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] byte_val;
    mode_t      mode;
  } plain_t;

  localparam int QDepth = 4;

  // plain-state handling of one byte
  function automatic plain_t plain_map(input logic [7:0] b);
    plain_t p;
    p.emit     = 1'b1;
    p.byte_val = b;
    p.mode     = MODE_PLAIN;
    case (b)
      BYTE_AT: p.byte_val = BYTE_NL;
      BYTE_E2: begin p.emit = 1'b0; p.mode = MODE_E2; end
      BYTE_C2: begin p.emit = 1'b0; p.mode = MODE_C2; end
      BYTE_C3: begin p.emit = 1'b0; p.mode = MODE_C3; end
      BYTE_NL: begin p.emit = 1'b0; p.mode = MODE_NL; end
      default: p.emit = 1'b1;
    endcase
    return p;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_eoi_r;

  result_t    res0, res1;
  logic [1:0] push_n;
  plain_t     pm;

  result_t    queue_r [QDepth];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r, count_nxt;
  logic       in_take, out_take;

  // handshakes
  assign out_valid = (count_r != 3'd0);
  assign out_take  = out_valid & ~out_stall;
  assign in_stall  = ((count_r + {1'b0, push_n}) > 3'd2);
  assign in_take   = in_valid & ~in_stall;

  assign out_byte        = queue_r[rd_ptr_r].byte_val;
  assign out_kind        = queue_r[rd_ptr_r].kind;
  assign out_last_of_run = queue_r[rd_ptr_r].last;

  // decode of the staged transaction
  always_comb begin
    res0     = '{byte_val: OUT_ZERO, kind: KIND_DATA, last: 1'b0};
    res1     = '{byte_val: OUT_ZERO, kind: KIND_DATA, last: 1'b0};
    push_n   = 2'd0;
    mode_nxt = mode_r;
    pm       = plain_map(stg_byte_r);
    if (stg_valid_r) begin
      case (mode_r)
        MODE_PLAIN: begin
          if (stg_eoi_r) begin
            res0.kind = KIND_END;
            push_n    = 2'd1;
          end else begin
            res0.byte_val = pm.byte_val;
            push_n        = pm.emit ? 2'd1 : 2'd0;
            mode_nxt      = pm.mode;
          end
        end
        MODE_NL: begin
          mode_nxt = MODE_PLAIN;
          if (stg_eoi_r) begin
            res0.kind = KIND_REC;
            res1.kind = KIND_END;
            push_n    = 2'd2;
          end else if (stg_byte_r == BYTE_NL) begin
            res0.kind = KIND_REC;
            push_n    = 2'd1;
          end else begin
            res0.byte_val = BYTE_NL;
            res1.byte_val = pm.byte_val;
            push_n        = pm.emit ? 2'd2 : 2'd1;
            mode_nxt      = pm.mode;
          end
        end
        MODE_E2, MODE_E2_99, MODE_C2, MODE_C3: begin
          mode_nxt = MODE_PLAIN;
          push_n   = 2'd1;
          if (stg_eoi_r) begin
            res0.kind = KIND_ERR;
            mode_nxt  = MODE_HALT;
          end else begin
            // assume a bad continuation, then override on a match
            res0.kind     = KIND_ERR;
            res0.byte_val = stg_byte_r;
            mode_nxt      = MODE_HALT;
            case (mode_r)
              MODE_E2: begin
                if (stg_byte_r == BYTE_99) begin
                  push_n   = 2'd0;
                  mode_nxt = MODE_E2_99;
                end
              end
              MODE_E2_99: begin
                if (stg_byte_r == BYTE_82 || stg_byte_r == BYTE_80) begin
                  res0.kind     = KIND_DATA;
                  res0.byte_val = (stg_byte_r == BYTE_82) ? OUT_A9 : OUT_BE;
                  mode_nxt      = MODE_PLAIN;
                end
              end
              MODE_C2: begin
                if (stg_byte_r == BYTE_A5 || stg_byte_r == BYTE_B7) begin
                  res0.kind     = KIND_DATA;
                  res0.byte_val = (stg_byte_r == BYTE_A5) ? OUT_A5 : OUT_B7;
                  mode_nxt      = MODE_PLAIN;
                end
              end
              default: begin
                if (stg_byte_r == BYTE_A9 || stg_byte_r == BYTE_97) begin
                  res0.kind     = KIND_DATA;
                  res0.byte_val = (stg_byte_r == BYTE_A9) ? OUT_E9 : OUT_D7;
                  mode_nxt      = MODE_PLAIN;
                end
              end
            endcase
          end
        end
        default: begin
          // halted: swallow everything
          push_n   = 2'd0;
          mode_nxt = MODE_HALT;
        end
      endcase
    end
    // mark the final result of this transaction
    if (push_n == 2'd1) res0.last = 1'b1;
    if (push_n == 2'd2) res1.last = 1'b1;
  end

  // input stage and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PLAIN;
      stg_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      stg_valid_r <= in_take;
    end
    if (in_take) begin
      stg_byte_r <= in_byte;
      stg_eoi_r  <= in_end_of_input;
    end
  end

  // result queue
  assign count_nxt = count_r + {1'b0, push_n} - {2'b00, out_take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      rd_ptr_r <= rd_ptr_r + {1'b0, out_take};
      count_r  <= count_nxt;
    end
    if (push_n != 2'd0) queue_r[wr_ptr_r] <= res0;
    if (push_n == 2'd2) queue_r[wr_ptr_r + 2'd1] <= res1;
  end

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QDepth))
    else $error("result queue overflow");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0 && res0.kind == KIND_ERR) |=> mode_r == MODE_HALT)
    else $error("error did not halt decoder");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HALT) |-> push_n == 2'd0)
    else $error("halted decoder produced a result");

  a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> stg_valid_r)
    else $error("accepted transaction not staged");

endmodule
